[rtl/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the scheduler checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/clook_pkg.sv]
// ============================================================================
// C-LOOK scheduler package
// Shared sizes, register indexes and inter-module records.
// ============================================================================
package clook_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CYL_W        = 16;
  localparam int SEEK_W       = 22;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP = 2'd1;

  // Write of one ranked request into the sorted store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [CYL_W-1:0] data;
  } sort_wr_t;

  // Start of the service sweep
  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] split;
  } launch_t;

endpackage

[rtl/clook_sort.sv]
// ============================================================================
// C-LOOK request loader and ranker
// Stores the batch, then ranks each request against all others with one
// shared comparator and writes it to its sorted place.
// ============================================================================
module clook_sort import clook_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [CYL_W-1:0] request_cylinder,
  input  logic             last_request,
  input  logic [CYL_W-1:0] head,
  output logic             busy,
  output sort_wr_t         wr,
  output launch_t          launch
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_KEY   = 3'd1;
  localparam logic [2:0] S_KEYW  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] split;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] pidx;
  logic             pend;
  logic [IDX_W-1:0] rank;
  logic [CYL_W-1:0] key;
  logic [CYL_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [CYL_W-1:0] store [MAX_REQUESTS];

  logic [CYL_W-1:0] opb;
  logic             lt;
  logic             eq;
  logic             inc;
  logic             full;
  logic             j_end;
  logic             i_end;
  logic [IDX_W-1:0] rank_fin;

  // Shared comparator: head during key fetch, key during scan
  assign opb      = (state == S_KEYW) ? head : key;
  assign lt       = rd_data < opb;
  assign eq       = rd_data == key;
  assign inc      = pend && (lt || (eq && (pidx < i)));
  assign full     = count == CNT_W'(MAX_REQUESTS);
  assign j_end    = {1'b0, j} == n - CNT_W'(1);
  assign i_end    = {1'b0, i} == n - CNT_W'(1);
  assign rank_fin = rank + IDX_W'(inc);
  assign rd_addr  = (state == S_SCAN) ? j : i;
  assign busy     = state != S_LOAD;

  // Drive the sorted-store write and the sweep launch
  always_comb begin
    wr.we        = state == S_DRAIN;
    wr.addr      = rank_fin;
    wr.data      = key;
    launch.go    = (state == S_DRAIN) && i_end;
    launch.n     = n;
    launch.split = split;
  end

  // Request store: one write port, registered read
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      store[count[IDX_W-1:0]] <= request_cylinder;
    end
    rd_data <= store[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (last_request) begin
              n     <= full ? count : count + CNT_W'(1);
              count <= '0;
              i     <= '0;
              split <= '0;
              state <= S_KEY;
            end else if (!full) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        S_KEY: begin
          state <= S_KEYW;
        end
        S_KEYW: begin
          key   <= rd_data;
          split <= split + CNT_W'(lt);
          j     <= '0;
          rank  <= '0;
          pend  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          pend <= 1'b1;
          pidx <= j;
          if (inc) begin
            rank <= rank + IDX_W'(1);
          end
          if (j_end) begin
            state <= S_DRAIN;
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (i_end) begin
            state <= S_LOAD;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_KEY;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[rtl/clook_emit.sv]
// ============================================================================
// C-LOOK service sweep
// Walks the sorted store in C-LOOK order and accumulates head travel through
// a three-stage read, distance and sum pipeline.
// ============================================================================
module clook_emit import clook_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sort_wr_t          wr,
  input  launch_t           launch,
  input  logic [CYL_W-1:0]  head,
  input  logic              sweep_down,
  output logic              active,
  output logic              result_valid,
  output logic [CYL_W-1:0]  served_cylinder,
  output logic [SEEK_W-1:0] seek_so_far,
  output logic              after_wrap,
  output logic              last_result
);

  logic [CYL_W-1:0] sorted [MAX_REQUESTS];

  logic             run;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] split;
  logic [CYL_W-1:0] rd_data;
  logic             va, wrap_a, last_a;
  logic             vb, wrap_b, last_b;
  logic [CYL_W-1:0] cyl_b;
  logic [CYL_W-1:0] diff_b;
  logic [CYL_W-1:0] cur;

  logic [CNT_W:0]   t_up;
  logic [CNT_W:0]   t_dn;
  logic [IDX_W-1:0] idx;
  logic             wrap_k;
  logic             last_k;
  logic [SEEK_W:0]  sum;

  // Service index for step k of the sweep
  always_comb begin
    t_up = {1'b0, split} + (CNT_W+1)'(k);
    if (t_up >= {1'b0, n}) begin
      t_up = t_up - {1'b0, n};
    end
    if ({1'b0, k} < split) begin
      t_dn = {1'b0, split} - (CNT_W+1)'(1) - (CNT_W+1)'(k);
    end else begin
      t_dn = {1'b0, n} + {1'b0, split} - (CNT_W+1)'(1) - (CNT_W+1)'(k);
    end
    idx    = sweep_down ? t_dn[IDX_W-1:0] : t_up[IDX_W-1:0];
    wrap_k = sweep_down ? ({1'b0, k} == split) : ({1'b0, k} == n - split);
    last_k = {1'b0, k} == n - CNT_W'(1);
  end

  assign sum    = {1'b0, seek_so_far} + (SEEK_W+1)'(diff_b);
  assign active = run || va || vb;

  // Sorted store: ranked write, registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      sorted[wr.addr] <= wr.data;
    end
    rd_data <= sorted[idx];
  end

  // Step counter and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      run          <= 1'b0;
      va           <= 1'b0;
      vb           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (launch.go) begin
        run   <= 1'b1;
        k     <= '0;
        n     <= launch.n;
        split <= launch.split;
      end else if (run) begin
        k <= k + IDX_W'(1);
        if (last_k) begin
          run <= 1'b0;
        end
      end
      va           <= run;
      vb           <= va;
      result_valid <= vb;
    end
  end

  // Distance stage: advance the head position
  always_ff @(posedge clk) begin
    wrap_a <= wrap_k;
    last_a <= last_k;
    if (launch.go) begin
      cur <= head;
    end else if (va) begin
      diff_b <= (rd_data > cur) ? rd_data - cur : cur - rd_data;
      cur    <= rd_data;
      cyl_b  <= rd_data;
      wrap_b <= wrap_a;
      last_b <= last_a;
    end
  end

  // Sum stage: accumulate travel, saturate at full scale
  always_ff @(posedge clk) begin
    if (launch.go) begin
      seek_so_far <= '0;
    end else if (vb) begin
      seek_so_far     <= sum[SEEK_W] ? '1 : sum[SEEK_W-1:0];
      served_cylinder <= cyl_b;
      after_wrap      <= wrap_b;
      last_result     <= last_b;
    end
  end

endmodule

[rtl/clook_disk_scheduler_top.sv]
// ============================================================================
// C-LOOK disk scheduler top level
// Loads a batch of cylinder requests and emits the C-LOOK service order.
// ============================================================================
//
// Channel   Handshake                  Payload
// request   start / busy               request_cylinder, last_request
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
// result    result_valid (strobe)      served_cylinder, seek_so_far,
//                                      after_wrap, last_result
//
// A request without the last mark leaves busy low. On the last mark the
// ranking loop orders a batch of n requests with one comparator and one
// store read port, then results stream one per cycle through the read,
// distance and sum pipeline registers. busy stays high until the sweep's
// final result is on the ports. Reset is synchronous and clears the batch
// count and the registers; results cannot be stalled.
//
module clook_disk_scheduler_top import clook_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CYL_W-1:0]     request_cylinder,
  input  logic                 last_request,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CYL_W-1:0]     cfg_data,
  output logic                 result_valid,
  output logic [CYL_W-1:0]     served_cylinder,
  output logic [SEEK_W-1:0]    seek_so_far,
  output logic                 after_wrap,
  output logic                 last_result
);

  logic [CYL_W-1:0] head_position;
  logic             sweep_down;
  logic             sort_busy;
  logic             emit_active;
  logic             accept;
  sort_wr_t         wr;
  launch_t          launch;

  assign cfg_ready = 1'b1;
  assign busy      = sort_busy || emit_active;
  assign accept    = start && !busy;

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      head_position <= '0;
      sweep_down    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAD:  head_position <= cfg_data;
        REG_SWEEP: sweep_down    <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  clook_sort u_sort (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .request_cylinder (request_cylinder),
    .last_request     (last_request),
    .head             (head_position),
    .busy             (sort_busy),
    .wr               (wr),
    .launch           (launch)
  );

  clook_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .wr              (wr),
    .launch          (launch),
    .head            (head_position),
    .sweep_down      (sweep_down),
    .active          (emit_active),
    .result_valid    (result_valid),
    .served_cylinder (served_cylinder),
    .seek_so_far     (seek_so_far),
    .after_wrap      (after_wrap),
    .last_result     (last_result)
  );

endmodule

[rtl/clook_checker.sv]
// ============================================================================
// C-LOOK scheduler port checker
// Watches the top-level ports for result sequencing against the transaction
// handshake.
// ============================================================================
`include "assert_macros.svh"

module clook_checker import clook_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid,
  input logic                 last_result
);

  // A result that is not the final one means the sweep is still running
  `CHK_ALWAYS(a_mid_busy, clk, rst, !(result_valid && !last_result) || busy, "result while idle")

  // Results of one sweep arrive back to back
  `CHK_NEXT(a_stream, clk, rst, result_valid && !last_result, result_valid, "gap in result stream")

  // The final result ends the stream
  `CHK_NEXT(a_end, clk, rst, result_valid && last_result, !result_valid, "result after final")

  // A new transaction never sees a stray result next cycle
  `CHK_NEXT(a_quiet, clk, rst, start && !busy, !result_valid, "result after accepted request")

endmodule

bind clook_disk_scheduler_top clook_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .last_result  (last_result)
);

[dv/clook_disk_scheduler_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK disk scheduler checker
// Watches the request, config and result channels, predicts the C-LOOK
// service order of each batch and compares every result field by field.
// ----------------------------------------------------------------------------
module clook_disk_scheduler_checker import clook_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CYL_W-1:0]     request_cylinder,
  input  logic                 last_request,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CYL_W-1:0]     cfg_data,
  input  logic                 result_valid,
  input  logic [CYL_W-1:0]     served_cylinder,
  input  logic [SEEK_W-1:0]    seek_so_far,
  input  logic                 after_wrap,
  input  logic                 last_result,
  output int                   mismatches,
  output int                   pending
);

  localparam logic [SEEK_W:0] TRAVEL_CEILING = 23'd4194303;

  typedef struct packed {
    logic [CYL_W-1:0]  cyl;
    logic [SEEK_W-1:0] seek;
    logic              wrap;
    logic              last;
  } service_t;

  service_t         service_due_q[$];
  service_t         got;
  service_t         want;
  logic [CYL_W-1:0] held_requests [MAX_REQUESTS];
  int               held_count;
  logic [CYL_W-1:0] head_reg;
  logic             sweep_down_reg;

  // Append one served request to the expected order and advance the head
  task automatic serve_next(input logic [CYL_W-1:0] cyl, input logic wrap,
                            input logic last, inout logic [CYL_W-1:0] pos,
                            inout logic [SEEK_W:0] travel);
    logic [CYL_W-1:0] move_len;
    service_t         entry;
    move_len = (cyl > pos) ? cyl - pos : pos - cyl;
    travel = travel + (SEEK_W+1)'(move_len);
    if (travel > TRAVEL_CEILING)
      travel = TRAVEL_CEILING;
    pos = cyl;
    entry.cyl  = cyl;
    entry.seek = travel[SEEK_W-1:0];
    entry.wrap = wrap;
    entry.last = last;
    service_due_q.push_back(entry);
  endtask

  // Rank the held batch and lay out the whole C-LOOK sweep
  task automatic plan_service_order();
    logic [CYL_W-1:0] ranked [MAX_REQUESTS];
    logic [CYL_W-1:0] key;
    logic [CYL_W-1:0] pos;
    logic [SEEK_W:0]  travel;
    int               n;
    int               i;
    int               j;
    int               split;
    int               k;
    n = held_count;
    for (i = 0; i < n; i++)
      ranked[i] = held_requests[i];
    for (i = 1; i < n; i++) begin
      key = ranked[i];
      j = i - 1;
      while (j >= 0 && ranked[j] > key) begin
        ranked[j + 1] = ranked[j];
        j--;
      end
      ranked[j + 1] = key;
    end
    split = 0;
    while (split < n && ranked[split] < head_reg)
      split++;
    pos = head_reg;
    travel = '0;
    k = 0;
    if (!sweep_down_reg) begin
      for (j = split; j < n; j++) begin
        serve_next(ranked[j], 1'b0, k == n - 1, pos, travel);
        k++;
      end
      for (j = 0; j < split; j++) begin
        serve_next(ranked[j], j == 0, k == n - 1, pos, travel);
        k++;
      end
    end else begin
      for (j = split - 1; j >= 0; j--) begin
        serve_next(ranked[j], 1'b0, k == n - 1, pos, travel);
        k++;
      end
      for (j = n - 1; j >= split; j--) begin
        serve_next(ranked[j], j == n - 1, k == n - 1, pos, travel);
        k++;
      end
    end
    held_count = 0;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    held_count = 0;
    head_reg = '0;
    sweep_down_reg = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      head_reg = '0;
      sweep_down_reg = 1'b0;
      service_due_q.delete();
    end else begin
      // Track register writes; unmapped indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEAD: begin
            head_reg = cfg_data;
          end
          REG_SWEEP: begin
            sweep_down_reg = cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      // Hold each accepted request; drop it once the batch is full
      if (start && !busy) begin
        if (held_count < MAX_REQUESTS) begin
          held_requests[held_count] = request_cylinder;
          held_count++;
        end
        if (last_request)
          plan_service_order();
      end

      // Compare each result transaction with the oldest expectation
      if (result_valid) begin
        got.cyl  = served_cylinder;
        got.seek = seek_so_far;
        got.wrap = after_wrap;
        got.last = last_result;
        if (service_due_q.size() == 0) begin
          $error("unexpected result: served_cylinder %0d seek_so_far %0d",
                 got.cyl, got.seek);
          mismatches++;
        end else begin
          want = service_due_q.pop_front();
          if (got.cyl !== want.cyl) begin
            $error("served_cylinder: expected %0d, got %0d", want.cyl, got.cyl);
            mismatches++;
          end
          if (got.seek !== want.seek) begin
            $error("seek_so_far: expected %0d, got %0d", want.seek, got.seek);
            mismatches++;
          end
          if (got.wrap !== want.wrap) begin
            $error("after_wrap: expected %0d, got %0d", want.wrap, got.wrap);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
    end
    pending = service_due_q.size();
  end

endmodule

[dv/clook_disk_scheduler_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK disk scheduler testbench
// Drives directed and random request batches and register settings into the
// scheduler with random pacing; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module clook_disk_scheduler_top_tb;
  import clook_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SETTLE_CYCLES = 4;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [CYL_W-1:0]     request_cylinder;
  logic                 last_request;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CYL_W-1:0]     cfg_data;
  logic                 result_valid;
  logic [CYL_W-1:0]     served_cylinder;
  logic [SEEK_W-1:0]    seek_so_far;
  logic                 after_wrap;
  logic                 last_result;
  int                   mismatches;
  int                   pending;
  int                   cycle_count;
  int                   random_sent;
  logic [CYL_W-1:0]     head_now;

  clook_disk_scheduler_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .request_cylinder (request_cylinder),
    .last_request     (last_request),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .served_cylinder  (served_cylinder),
    .seek_so_far      (seek_so_far),
    .after_wrap       (after_wrap),
    .last_result      (last_result)
  );

  clook_disk_scheduler_checker u_chk (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .request_cylinder (request_cylinder),
    .last_request     (last_request),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .served_cylinder  (served_cylinder),
    .seek_so_far      (seek_so_far),
    .after_wrap       (after_wrap),
    .last_result      (last_result),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run in case the block hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request and hold it until the block takes the transaction
  task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last_flag);
    @(negedge clk);
    start <= 1'b1;
    request_cylinder <= cyl;
    last_request <= last_flag;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a number of cycles
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every expected result has come out
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register over the config channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CYL_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_HEAD)
      head_now = data;
  endtask

  function automatic int pick_gap(input int pace);
    int roll;
    roll = $urandom_range(0, 99);
    if (pace == 0)
      return 0;
    if (roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Mix full-range values with values around the head, repeats, extremes and small values
  function automatic logic [CYL_W-1:0] pick_cylinder(input logic [CYL_W-1:0] head,
                                                     input logic [CYL_W-1:0] prev);
    int roll;
    int near;
    roll = $urandom_range(0, 99);
    if (roll < 40)
      return CYL_W'($urandom_range(0, 65535));
    if (roll < 60) begin
      near = int'(head) + $urandom_range(0, 80) - 40;
      if (near < 0)
        near = 0;
      if (near > 65535)
        near = 65535;
      return CYL_W'(near);
    end
    if (roll < 70)
      return head;
    if (roll < 80)
      return prev;
    if (roll < 90)
      return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    return CYL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CYL_W-1:0] pick_head();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return 16'h0000;
    if (roll == 1)
      return 16'hFFFF;
    if (roll == 2)
      return 16'h8000;
    return CYL_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int               n;
    int               i;
    int               pace;
    int               gap;
    bit               first_batch;
    logic [CYL_W-1:0] cyl;
    logic [CYL_W-1:0] prev;

    rst = 1'b1;
    start = 1'b0;
    request_cylinder = '0;
    last_request = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_HEAD;
    cfg_data = '0;
    head_now = '0;
    random_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Upward sweep: extremes, a request equal to the head, wrap to the lowest
    write_reg(REG_HEAD, 16'd100);
    write_reg(REG_SWEEP, 16'h0000);
    send_request(16'd150, 1'b0);
    send_request(16'd50, 1'b0);
    send_request(16'd100, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b1);

    // Downward sweep; upper data bits of the sweep register are don't-care
    wait_quiet();
    write_reg(REG_SWEEP, 16'hFFFF);
    send_request(16'd100, 1'b0);
    send_request(16'd30, 1'b0);
    send_request(16'd200, 1'b1);

    // Nothing below the head going down: first move is the wrap
    wait_quiet();
    write_reg(REG_HEAD, 16'h0000);
    send_request(16'd7, 1'b0);
    send_request(16'd3, 1'b1);

    // Nothing above the head going up: first move is the wrap
    wait_quiet();
    write_reg(REG_HEAD, 16'hFFFF);
    write_reg(REG_SWEEP, 16'hFFFE);
    send_request(16'd10, 1'b0);
    send_request(16'd20, 1'b1);

    // Duplicates equal to the head going down are served after the wrap
    wait_quiet();
    write_reg(REG_SWEEP, 16'h0001);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFF, 1'b1);

    // Unmapped indexes, then a register change while a batch is loading
    wait_quiet();
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hFFFF);
    write_reg(REG_HEAD, 16'd500);
    write_reg(REG_SWEEP, 16'h0000);
    send_request(16'd600, 1'b0);
    wait_quiet();
    write_reg(REG_HEAD, 16'd700);
    write_reg(REG_SWEEP, 16'h0001);
    send_request(16'd650, 1'b1);

    // Random batches; the first overfills the store
    first_batch = 1'b1;
    prev = '0;
    while (random_sent < RANDOM_ITEMS) begin
      if (first_batch || $urandom_range(0, 2) == 0) begin
        wait_quiet();
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_HEAD, pick_head());
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_SWEEP, CYL_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 5) == 0)
          write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_B : REG_SPARE_A,
                    CYL_W'($urandom_range(0, 65535)));
      end
      if (first_batch)
        n = MAX_REQUESTS + 2;
      else if ($urandom_range(0, 11) == 0)
        n = $urandom_range(MAX_REQUESTS - 2, MAX_REQUESTS + 4);
      else
        n = $urandom_range(1, 10);
      first_batch = 1'b0;
      pace = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
        cyl = pick_cylinder(head_now, prev);
        send_request(cyl, i == n - 1);
        prev = cyl;
        random_sent++;
        gap = pick_gap(pace);
        if (gap > 0)
          hold_off(gap);
      end
    end

    // Drain the last batch and give the block time to misbehave
    @(negedge clk);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
